// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the slot table.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sst_pkg.sv -----
// Shared types and constants of the slot table: operation and status codes,
// port field widths and bit positions. Depends on nothing.
package sst_pkg;

    localparam int FUNC_W      = 2;
    localparam int IDX_PORT_W  = 10;
    localparam int WORD_PORT_W = 32;
    localparam int CNT_PORT_W  = 11;
    localparam int STATUS_W    = 2;

    // Input word: slot_index, write_value; func in tuser
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;
    localparam int S_IDX_LSB  = 0;
    localparam int S_WORD_LSB = 10;

    // Output word: read_value, written_index, lowest, highest, count; status in tuser
    localparam int M_TDATA_W  = 80;
    localparam int M_TUSER_W  = 2;
    localparam int M_RD_LSB   = 0;
    localparam int M_WIDX_LSB = 32;
    localparam int M_LOW_LSB  = 42;
    localparam int M_HIGH_LSB = 52;
    localparam int M_CNT_LSB  = 62;
    localparam int M_PAD_W    = 7;

    localparam logic [CNT_PORT_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET    = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_PUSH   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NOT_VALID = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

// ----- hw/rtl/sst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/sparse_slot_table.sv -----
// Slot table with a valid bitmap kept in rows of up to 32 bits.
//
// Input channel s_*: one request word per handshake, func in s_tuser,
// slot_index and write_value in s_tdata. Output channel m_*: one result word
// per request, status in m_tuser, the rest in m_tdata. cfg_wr_en/cfg_wr_data
// write capacity_in_use; write it only while the block is idle.
//
// A request is worked in steps: request latch, memory read, update and result
// load. The result is loaded into the output register as the block returns to
// idle, together with s_tready rising again, so a new request is taken only after
// the last one is through; a refused request skips the update.
// A remove of the lowest or highest valid slot that does not find the new bound
// in its own bitmap row scans neighbor rows through the shared priority finder,
// reading each row in S_SCAN_RD and checking it in S_SCAN_CHK.
//
// After reset the bitmap is swept clear, one row a cycle, with s_tready low. When
// the receiver stalls the result holds in the output register; the next request
// is accepted and worked, then waits for the output register before the one
// after it.
// Depends on sst_pkg and sst_ram.
module sparse_slot_table #(
    parameter int SLOT_COUNT = 1024,
    parameter int WORD_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sst_pkg::S_TDATA_W-1:0]    s_tdata,   // slot_index, write_value, pad
    input  logic [sst_pkg::S_TUSER_W-1:0]    s_tuser,   // func
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_value, written_index, lowest_valid, highest_valid, valid_count, pad
    output logic [sst_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [sst_pkg::M_TUSER_W-1:0]    m_tuser,   // status
    input  logic                             cfg_wr_en,
    input  logic [sst_pkg::CNT_PORT_W-1:0]   cfg_wr_data
);

    import sst_pkg::*;

    localparam int IDXW  = $clog2(SLOT_COUNT);
    localparam int CNTW  = $clog2(SLOT_COUNT + 1);
    localparam int ROW_W = (SLOT_COUNT < 32) ? SLOT_COUNT : 32;
    localparam int ROWS  = (SLOT_COUNT + ROW_W - 1) / ROW_W;
    localparam int BW    = $clog2(ROW_W);
    localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_LOOK     = 7'b0000100,
        S_EXEC     = 7'b0001000,
        S_SCAN_RD  = 7'b0010000,
        S_SCAN_CHK = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    function automatic logic [RAW-1:0] row_of(input logic [IDXW-1:0] a);
        return RAW'(a >> BW);
    endfunction

    // Priority finder: lowest set bit when up, highest otherwise; top bit = found
    function automatic logic [BW:0] prio_find(input logic [ROW_W-1:0] v, input logic up);
        logic [BW:0] r;
        int          j;
        r = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            j = up ? (ROW_W - 1 - i) : i;
            if (v[j])
            begin
                r = {1'b1, BW'(j)};
            end
        end
        return r;
    endfunction

    state_t                 state_reg, state_next;
    logic [CNT_PORT_W-1:0]  cap_cfg_reg;
    func_t                  func_reg, func_next;
    logic [IDX_PORT_W-1:0]  idx_in_reg, idx_in_next;
    logic [WORD_WIDTH-1:0]  word_reg, word_next;
    logic [IDXW-1:0]        addr_reg, addr_next;
    logic [IDXW-1:0]        low_reg, low_next;
    logic [IDXW-1:0]        high_reg, high_next;
    logic [CNTW-1:0]        count_reg, count_next;
    status_t                status_reg, status_next;
    logic [IDXW-1:0]        widx_reg, widx_next;
    logic [WORD_WIDTH-1:0]  rdval_reg, rdval_next;
    logic [RAW-1:0]         scan_row_reg, scan_row_next;
    logic                   scan_up_reg, scan_up_next;
    logic [RAW-1:0]         clear_row_reg, clear_row_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]   m_tuser_reg, m_tuser_next;

    logic [CNTW-1:0]        cap_eff;
    logic [IDXW:0]          push_target;
    logic                   push_full;
    logic                   range_bad;
    logic [IDXW-1:0]        look_addr;

    logic                   row_we;
    logic [RAW-1:0]         row_waddr;
    logic [ROW_W-1:0]       row_wdata;
    logic [RAW-1:0]         row_raddr;
    logic [ROW_W-1:0]       row_q;
    logic                   data_we;
    logic [WORD_WIDTH-1:0]  word_q;

    logic [BW-1:0]          bit_pos;
    logic                   cur_bit;
    logic [ROW_W-1:0]       row_mod;
    logic [ROW_W-1:0]       enc_in;
    logic                   enc_up;
    logic [RAW-1:0]         enc_row;
    logic [BW:0]            enc_out;
    logic [IDXW-1:0]        enc_idx;

    // Clamp the capacity register into 1..SLOT_COUNT
    always_comb
    begin
        if (cap_cfg_reg == '0)
        begin
            cap_eff = CNTW'(1);
        end
        else if (32'(cap_cfg_reg) > 32'(SLOT_COUNT))
        begin
            cap_eff = CNTW'(SLOT_COUNT);
        end
        else
        begin
            cap_eff = CNTW'(cap_cfg_reg);
        end
    end

    assign push_target = (count_reg == '0) ? '0 : ({1'b0, high_reg} + (IDXW+1)'(1));
    assign push_full   = 32'(push_target) >= 32'(cap_eff);
    assign range_bad   = 32'(idx_in_reg) >= 32'(cap_eff);
    assign look_addr   = (func_reg == FUNC_PUSH) ? IDXW'(push_target) : IDXW'(idx_in_reg);

    assign bit_pos = addr_reg[BW-1:0];
    assign cur_bit = row_q[bit_pos];

    always_comb
    begin
        row_mod = row_q;
        row_mod[bit_pos] = (func_reg != FUNC_REMOVE);
    end

    // Shared priority finder: on the updated row during the update cycle,
    // on the fetched neighbor row during a scan
    assign enc_in  = (state_reg == S_EXEC) ? row_mod : row_q;
    assign enc_up  = (state_reg == S_EXEC) ? (addr_reg == low_reg) : scan_up_reg;
    assign enc_row = (state_reg == S_EXEC) ? row_of(addr_reg) : scan_row_reg;
    assign enc_out = prio_find(enc_in, enc_up);
    assign enc_idx = IDXW'({enc_row, enc_out[BW-1:0]});

    assign row_raddr = (state_reg == S_LOOK) ? row_of(look_addr) : scan_row_reg;

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        idx_in_next    = idx_in_reg;
        word_next      = word_reg;
        addr_next      = addr_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        widx_next      = widx_reg;
        rdval_next     = rdval_reg;
        scan_row_next  = scan_row_reg;
        scan_up_next   = scan_up_reg;
        clear_row_next = clear_row_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        row_we         = 1'b0;
        row_waddr      = row_of(addr_reg);
        row_wdata      = row_mod;
        data_we        = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                row_we    = 1'b1;
                row_waddr = clear_row_reg;
                row_wdata = '0;
                clear_row_next = clear_row_reg + RAW'(1);
                if (clear_row_reg == RAW'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next   = func_t'(s_tuser[FUNC_W-1:0]);
                    idx_in_next = s_tdata[S_IDX_LSB +: IDX_PORT_W];
                    word_next   = WORD_WIDTH'(s_tdata[S_WORD_LSB +: WORD_PORT_W]);
                    status_next = ST_OK;
                    widx_next   = '0;
                    rdval_next  = '0;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                addr_next = look_addr;
                if (func_reg == FUNC_PUSH && push_full)
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else if (func_reg != FUNC_PUSH && range_bad)
                begin
                    status_next = ST_RANGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (func_reg)
                    FUNC_SET, FUNC_PUSH:
                    begin
                        data_we   = 1'b1;
                        widx_next = addr_reg;
                        if (!cur_bit)
                        begin
                            row_we     = 1'b1;
                            count_next = count_reg + CNTW'(1);
                            if (count_reg == '0)
                            begin
                                low_next  = addr_reg;
                                high_next = addr_reg;
                            end
                            else
                            begin
                                if (addr_reg < low_reg)
                                begin
                                    low_next = addr_reg;
                                end
                                if (addr_reg > high_reg)
                                begin
                                    high_next = addr_reg;
                                end
                            end
                        end
                    end
                    FUNC_GET:
                    begin
                        if (cur_bit)
                        begin
                            rdval_next = word_q;
                        end
                        else
                        begin
                            status_next = ST_NOT_VALID;
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (!cur_bit)
                        begin
                            status_next = ST_NOT_VALID;
                        end
                        else
                        begin
                            row_we     = 1'b1;
                            count_next = count_reg - CNTW'(1);
                            if (count_reg == CNTW'(1))
                            begin
                                low_next  = '0;
                                high_next = '0;
                            end
                            else if (addr_reg == low_reg || addr_reg == high_reg)
                            begin
                                scan_up_next = enc_up;
                                if (enc_out[BW])
                                begin
                                    if (enc_up)
                                    begin
                                        low_next = enc_idx;
                                    end
                                    else
                                    begin
                                        high_next = enc_idx;
                                    end
                                end
                                else
                                begin
                                    // Advance to the neighbor row
                                    scan_row_next = enc_up ? (row_of(addr_reg) + RAW'(1))
                                                           : (row_of(addr_reg) - RAW'(1));
                                    state_next    = S_SCAN_RD;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (enc_out[BW])
                begin
                    if (scan_up_reg)
                    begin
                        low_next = enc_idx;
                    end
                    else
                    begin
                        high_next = enc_idx;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    scan_row_next = scan_up_reg ? (scan_row_reg + RAW'(1))
                                                : (scan_row_reg - RAW'(1));
                    state_next    = S_SCAN_RD;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = M_TUSER_W'(status_reg);
                    m_tdata_next  = {{M_PAD_W{1'b0}},
                                     CNT_PORT_W'(count_reg),
                                     IDX_PORT_W'(high_reg),
                                     IDX_PORT_W'(low_reg),
                                     IDX_PORT_W'(widx_reg),
                                     WORD_PORT_W'(rdval_reg)};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cap_cfg_reg   <= CAP_RESET;
            low_reg       <= '0;
            high_reg      <= '0;
            count_reg     <= '0;
            clear_row_reg <= '0;
            scan_up_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            count_reg     <= count_next;
            clear_row_reg <= clear_row_next;
            scan_up_reg   <= scan_up_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                cap_cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        idx_in_reg   <= idx_in_next;
        word_reg     <= word_next;
        addr_reg     <= addr_next;
        status_reg   <= status_next;
        widx_reg     <= widx_next;
        rdval_reg    <= rdval_next;
        scan_row_reg <= scan_row_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    sst_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_valid_rows (
        .clk     (clk),
        .wr_en   (row_we),
        .wr_addr (row_waddr),
        .wr_data (row_wdata),
        .rd_addr (row_raddr),
        .rd_data (row_q)
    );

    sst_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (SLOT_COUNT)
    ) u_slot_data (
        .clk     (clk),
        .wr_en   (data_we),
        .wr_addr (addr_reg),
        .wr_data (word_reg),
        .rd_addr (look_addr),
        .rd_data (word_q)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- hw/rtl/sst_checker.sv -----
// Port-level checks of the slot table's result channel, bound to the top level.
// Depends on sst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sst_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sst_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sst_pkg::M_TUSER_W-1:0] m_tuser
);

    import sst_pkg::*;

    logic [WORD_PORT_W-1:0] rd_val;
    logic [IDX_PORT_W-1:0]  widx;
    logic [IDX_PORT_W-1:0]  low_idx;
    logic [IDX_PORT_W-1:0]  high_idx;
    logic [CNT_PORT_W-1:0]  cnt;

    assign rd_val   = m_tdata[M_RD_LSB +: WORD_PORT_W];
    assign widx     = m_tdata[M_WIDX_LSB +: IDX_PORT_W];
    assign low_idx  = m_tdata[M_LOW_LSB +: IDX_PORT_W];
    assign high_idx = m_tdata[M_HIGH_LSB +: IDX_PORT_W];
    assign cnt      = m_tdata[M_CNT_LSB +: CNT_PORT_W];

    `SST_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed under stall")

    `SST_ASSERT_IMPLY(a_empty_bounds, clk, rst_n, m_tvalid && cnt == '0,
        low_idx == '0 && high_idx == '0, "empty table reports nonzero bounds")

    `SST_ASSERT_IMPLY(a_bound_order, clk, rst_n, m_tvalid && cnt != '0,
        low_idx <= high_idx, "lowest valid above highest valid")

    `SST_ASSERT_IMPLY(a_fail_clean, clk, rst_n, m_tvalid && m_tuser != ST_OK,
        widx == '0 && rd_val == '0, "refused request reports data")

endmodule

bind sparse_slot_table sst_checker u_sst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of sparse_slot_table: directed and random requests on the
// stream ports, with every result checked against a slot table predictor kept here.
// Depends on sst_pkg and the sparse_slot_table RTL.
module testbench;
    import sst_pkg::*;

    localparam int SLOTS         = 1024;
    localparam int IDLE_LIMIT    = 3000;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 40;
    localparam int PHASE_ITEMS   = 160;

    typedef struct {
        logic [WORD_PORT_W-1:0] read_value;
        status_t                status;
        logic [IDX_PORT_W-1:0]  written_index;
        logic [IDX_PORT_W-1:0]  lowest_valid;
        logic [IDX_PORT_W-1:0]  highest_valid;
        logic [CNT_PORT_W-1:0]  valid_count;
    } slot_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // slot_index, write_value, pad
    logic [S_TUSER_W-1:0]  s_tuser = '0;   // func
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // read_value, written_index, lowest_valid, highest_valid, valid_count, pad
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;        // status
    logic                  cfg_wr_en = 1'b0;
    logic [CNT_PORT_W-1:0] cfg_wr_data = '0;

    // Predictor state of the table
    bit                     shadow_valid [SLOTS];
    logic [WORD_PORT_W-1:0] shadow_word [SLOTS];
    int                     shadow_low;
    int                     shadow_high;
    int                     shadow_count;
    int                     capacity_reg = CAP_RESET;

    slot_result_t pending_results [$];
    slot_result_t oldest_result;

    int mismatch_count;
    int requests_sent;
    int results_checked;
    int func_seen [4];
    int status_seen [4];
    int burst_left;
    int idle_cycles;
    int hold_requests;
    int holds_taken;
    int hold_left;
    int stall_mode;
    int mode_left;
    int rx_phase;

    sparse_slot_table u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #10 clk = ~clk;

    function automatic int effective_capacity();
        if (capacity_reg == 0)
            return 1;
        if (capacity_reg > SLOTS)
            return SLOTS;
        return capacity_reg;
    endfunction

    function automatic void store_word(int slot, logic [WORD_PORT_W-1:0] word);
        shadow_word[slot] = word;
        if (!shadow_valid[slot])
        begin
            shadow_valid[slot] = 1'b1;
            if (shadow_count == 0)
            begin
                shadow_low  = slot;
                shadow_high = slot;
            end
            else
            begin
                if (slot < shadow_low)
                    shadow_low = slot;
                if (slot > shadow_high)
                    shadow_high = slot;
            end
            shadow_count++;
        end
    endfunction

    // Full rescan after a remove; empty table reports both bounds as 0
    function automatic void find_bounds();
        shadow_low  = 0;
        shadow_high = 0;
        if (shadow_count != 0)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (shadow_valid[i])
                begin
                    shadow_low = i;
                    break;
                end
            end
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (shadow_valid[i])
                begin
                    shadow_high = i;
                    break;
                end
            end
        end
    endfunction

    function automatic slot_result_t predict_table(func_t op, int slot,
                                                   logic [WORD_PORT_W-1:0] word);
        slot_result_t r;
        int           cap;
        int           target;
        cap = effective_capacity();
        r.read_value    = '0;
        r.status        = ST_OK;
        r.written_index = '0;
        if (op == FUNC_PUSH)
        begin
            target = (shadow_count == 0) ? 0 : shadow_high + 1;
            if (target >= cap)
                r.status = ST_FULL;
            else
            begin
                store_word(target, word);
                r.written_index = IDX_PORT_W'(target);
            end
        end
        else if (slot >= cap)
            r.status = ST_RANGE;
        else if (op == FUNC_SET)
        begin
            store_word(slot, word);
            r.written_index = IDX_PORT_W'(slot);
        end
        else if (op == FUNC_GET)
        begin
            if (shadow_valid[slot])
                r.read_value = shadow_word[slot];
            else
                r.status = ST_NOT_VALID;
        end
        else if (!shadow_valid[slot])
            r.status = ST_NOT_VALID;
        else
        begin
            shadow_valid[slot] = 1'b0;
            shadow_count--;
            find_bounds();
        end
        r.lowest_valid  = IDX_PORT_W'(shadow_low);
        r.highest_valid = IDX_PORT_W'(shadow_high);
        r.valid_count   = CNT_PORT_W'(shadow_count);
        return r;
    endfunction

    // Bursts of random length, with a random gap before most of them
    task automatic pace_sender();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_request(func_t op, int slot, logic [WORD_PORT_W-1:0] word);
        logic [S_TDATA_W-1:0] packed_word;
        packed_word = '0;
        packed_word[S_IDX_LSB +: IDX_PORT_W]   = IDX_PORT_W'(slot);
        packed_word[S_WORD_LSB +: WORD_PORT_W] = word;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= packed_word;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_table(op, slot, word));
        requests_sent++;
        func_seen[op]++;
        pace_sender();
    endtask

    // Hold the input until every expected word has come back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CNT_PORT_W-1:0] value);
        wait_all_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        capacity_reg = value;
    endtask

    // Restore the default capacity, then empty the table by removing boundary slots, which drives the bound scans
    task automatic clear_table();
        write_capacity(CAP_RESET);
        while (shadow_count != 0)
            send_request(FUNC_REMOVE, ($urandom_range(0, 1) != 0) ? shadow_low : shadow_high,
                         '0);
    endtask

    task automatic send_random_request();
        func_t                  op;
        int                     slot;
        int                     pick;
        int                     cap;
        logic [WORD_PORT_W-1:0] word;
        cap  = effective_capacity();
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0, 1, 2: op = FUNC_SET;
            3, 4:    op = FUNC_GET;
            5, 6:    op = FUNC_REMOVE;
            default: op = FUNC_PUSH;
        endcase
        if (pick < 10)
            slot = $urandom_range(0, SLOTS - 1);
        else if (op == FUNC_REMOVE && shadow_count > 0 && pick < 45)
            slot = (pick < 28) ? shadow_low : shadow_high;
        else if (op != FUNC_SET && shadow_count > 0 && pick < 70)
            slot = $urandom_range(shadow_low, shadow_high);
        else
            slot = $urandom_range(0, cap - 1);
        case ($urandom_range(0, 7))
            0:       word = '0;
            1:       word = '1;
            default: word = $urandom;
        endcase
        send_request(op, slot, word);
    endtask

    task automatic test_empty_table();
        send_request(FUNC_GET, 5, '0);
        send_request(FUNC_REMOVE, 5, '0);
        send_request(FUNC_PUSH, 0, 32'h0000_0000);
        send_request(FUNC_PUSH, 1023, 32'hFFFF_FFFF);   // index ignored by push
        send_request(FUNC_SET, 1023, 32'hAAAA_AAAA);
        send_request(FUNC_GET, 1023, '0);
        send_request(FUNC_SET, 1023, 32'h5555_5555);   // overwrite, count unchanged
        send_request(FUNC_PUSH, 0, 32'h1234_5678);      // target past the last slot
        send_request(FUNC_REMOVE, 1023, '0);
        send_request(FUNC_REMOVE, 0, '0);
        send_request(FUNC_GET, 1, '0);
        send_request(FUNC_REMOVE, 1, '0);
        send_request(FUNC_GET, 0, '0);
    endtask

    task automatic test_capacity_limits();
        write_capacity(11'd0);       // acts as one slot
        send_request(FUNC_PUSH, 0, 32'hDEAD_BEEF);
        send_request(FUNC_PUSH, 0, 32'h0BAD_F00D);
        send_request(FUNC_SET, 1, 32'h1111_1111);
        send_request(FUNC_GET, 0, '0);
        send_request(FUNC_REMOVE, 0, '0);
        write_capacity(11'h7FF);     // clamps to the slot count
        send_request(FUNC_SET, 700, 32'hCAFE_0700);
        send_request(FUNC_SET, 3, 32'hCAFE_0003);
        // lower the capacity under a live slot: it stays counted but is refused
        write_capacity(11'd100);
        send_request(FUNC_GET, 700, '0);
        send_request(FUNC_PUSH, 0, 32'h7777_7777);
        send_request(FUNC_SET, 50, 32'hCAFE_0050);
        send_request(FUNC_GET, 3, '0);
        write_capacity(CAP_RESET);
        send_request(FUNC_REMOVE, 700, '0);
        send_request(FUNC_REMOVE, 3, '0);
        send_request(FUNC_REMOVE, 50, '0);
    endtask

    task automatic test_random_traffic();
        int  cap;
        bit  clear_first;
        for (int phase = 0; phase < 8; phase++)
        begin
            clear_first = 1'b0;
            case (phase)
                0:       cap = SLOTS;
                1:
                begin
                    cap = 16;
                    clear_first = 1'b1;
                end
                2:
                begin
                    cap = 64;
                    clear_first = 1'b1;
                end
                3:
                begin
                    cap = 1;
                    clear_first = 1'b1;
                end
                4:       cap = $urandom_range(2, SLOTS - 1);
                5:       cap = 11'h7FF;
                6:
                begin
                    cap = $urandom_range(2, 40);
                    clear_first = 1'b1;
                end
                default: cap = SLOTS;
            endcase
            if (clear_first)
                clear_table();
            write_capacity(CNT_PORT_W'(cap));
            if (phase == 7)
                hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    wait_all_results();
                send_random_request();
            end
        end
    endtask

    // Receiver: changing stall patterns, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (holds_taken != hold_requests)
        begin
            hold_left   = LONG_HOLD;
            holds_taken = hold_requests;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 128);
        end
        mode_left--;
        rx_phase++;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (rx_phase % 5 == 0);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    function automatic void check_field(string name, logic [WORD_PORT_W-1:0] want,
                                        logic [WORD_PORT_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_checked++;
            status_seen[m_tuser]++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, expected none, actual %h/%h",
                             $time, m_tuser, m_tdata);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("read_value", oldest_result.read_value,
                            m_tdata[M_RD_LSB +: WORD_PORT_W]);
                check_field("status", oldest_result.status, m_tuser);
                check_field("written_index", oldest_result.written_index,
                            m_tdata[M_WIDX_LSB +: IDX_PORT_W]);
                check_field("lowest_valid", oldest_result.lowest_valid,
                            m_tdata[M_LOW_LSB +: IDX_PORT_W]);
                check_field("highest_valid", oldest_result.highest_valid,
                            m_tdata[M_HIGH_LSB +: IDX_PORT_W]);
                check_field("valid_count", oldest_result.valid_count,
                            m_tdata[M_CNT_LSB +: CNT_PORT_W]);
            end
        end
    end

    // Watchdog: end the run when neither side moves a word for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending_results.size());
            $display("FAIL sparse_slot_table");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_capacity_limits();
        test_random_traffic();
        wait_all_results();
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            mismatch_count++;
        $display("Covered %0d requests (set %0d, get %0d, remove %0d, push %0d), %0d results",
                 requests_sent, func_seen[FUNC_SET], func_seen[FUNC_GET],
                 func_seen[FUNC_REMOVE], func_seen[FUNC_PUSH], results_checked);
        $display("Statuses: ok %0d, out of range %0d, not valid %0d, full %0d; %0d mismatches",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_NOT_VALID],
                 status_seen[ST_FULL], mismatch_count);
        if (mismatch_count == 0)
            $display("PASS sparse_slot_table");
        else
            $display("FAIL sparse_slot_table");
        $finish;
    end

endmodule

// ----- sparse_slot_table.f -----
+incdir+hw/rtl
hw/rtl/sst_pkg.sv
hw/rtl/sst_ram.sv
hw/rtl/sparse_slot_table.sv
hw/rtl/sst_checker.sv
verif/testbench.sv
